// ===== hdl/cmsc_pkg.sv =====
// Shared types, constants and hash helpers for the count-min sketch block.
// Used by cmsc_front, cmsc_queue, cmsc_back and count_min_sketch_crc_rows.
package cmsc_pkg;

   localparam int MAX_ROWS  = 4;
   localparam int MAX_WIDTH = 1024;
   localparam int POLY_REGS = 4;
   localparam int LANES     = (MAX_ROWS < POLY_REGS) ? MAX_ROWS : POLY_REGS;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int REM_W     = COL_W + 1;
   localparam int ROWS_W    = 3;
   localparam int WID_W     = 11;
   localparam int KEY_BYTES = 13;
   localparam int KEY_W     = 8 * KEY_BYTES;
   localparam int BCNT_W    = $clog2(KEY_BYTES + 1);
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = 32 / MOD_BITS;
   localparam int MSTEP_W   = $clog2(MOD_STEPS);
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Input actions.
   typedef enum logic [1:0] {
      ACT_UPD_INT  = 2'd0,
      ACT_UPD_FLOW = 2'd1,
      ACT_EST_INT  = 2'd2,
      ACT_EST_FLOW = 2'd3
   } action_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_ROW_COUNT = 3'd0;
   localparam logic [2:0] REG_WIDTH     = 3'd1;
   localparam logic [2:0] REG_POLY_0    = 3'd2;
   localparam logic [2:0] REG_POLY_1    = 3'd3;
   localparam logic [2:0] REG_POLY_2    = 3'd4;
   localparam logic [2:0] REG_POLY_3    = 3'd5;

   typedef enum logic [1:0] {F_IDLE, F_CRC, F_MOD, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ} back_state_type;

   // Configuration as seen by the front end.
   typedef struct packed {
      logic [ROWS_W-1:0]              row_count;
      logic [WID_W-1:0]               width;
      logic [POLY_REGS-1:0][31:0]     poly;
   } cfg_type;

   // One classified item, passed from the front end to the back end.
   typedef struct packed {
      logic                           update;
      logic [31:0]                    amount;
      logic [ROWS_W-1:0]              rows;
      logic [LANES-1:0][COL_W-1:0]    col;
   } job_type;

   // Queue status seen by the producer and the consumer.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [31:0] bit_rev32(input logic [31:0] v);
      logic [31:0] r;
      for (int b = 0; b < 32; b++) begin
         r[b] = v[31-b];
      end
      return r;
   endfunction

   // One byte through a reflected CRC-32.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [31:0] rpoly,
                                            input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/cmsc_front.sv =====
// Front end: accepts items, hashes the key for every row and reduces the
// hash to a column. Depends on cmsc_pkg.
module cmsc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hold,
   input  cmsc_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_action,
   input  logic [31:0]             req_int_key,
   input  logic [31:0]             req_increment,
   input  logic [31:0]             req_src_ip,
   input  logic [31:0]             req_dst_ip,
   input  logic [7:0]              req_proto,
   input  logic [15:0]             req_src_port,
   input  logic [15:0]             req_dst_port,
   input  cmsc_pkg::queue_status_type qstat,
   output logic                    push,
   output cmsc_pkg::job_type       job
);

   cmsc_pkg::front_state_type state_ff, state_in;
   logic [cmsc_pkg::KEY_W-1:0]                     key_ff, key_in;
   logic [cmsc_pkg::BCNT_W-1:0]                    bcnt_ff, bcnt_in;
   logic [cmsc_pkg::MSTEP_W-1:0]                   mstep_ff, mstep_in;
   logic                                           update_ff, update_in;
   logic [31:0]                                    amount_ff, amount_in;
   logic [cmsc_pkg::ROWS_W-1:0]                    rows_ff, rows_in;
   logic [cmsc_pkg::REM_W-1:0]                     weff_ff, weff_in;
   logic [cmsc_pkg::LANES-1:0][31:0]               rpoly_ff, rpoly_in;
   logic [cmsc_pkg::LANES-1:0][31:0]               crc_ff, crc_in;
   logic [cmsc_pkg::LANES-1:0][cmsc_pkg::COL_W-1:0] rem_ff, rem_in;
   logic                                           accept;
   logic                                           flow;

   assign flow   = req_action[0];
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmsc_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff    <= key_in;
      bcnt_ff   <= bcnt_in;
      mstep_ff  <= mstep_in;
      update_ff <= update_in;
      amount_ff <= amount_in;
      rows_ff   <= rows_in;
      weff_ff   <= weff_in;
      rpoly_ff  <= rpoly_in;
      crc_ff    <= crc_in;
      rem_ff    <= rem_in;
   end

   // Sequencer: load, one key byte per cycle, four quotient bits per cycle, push.
   always_comb begin
      logic [cmsc_pkg::REM_W-1:0] r;
      logic [31:0]                d;
      r         = '0;
      d         = '0;
      state_in  = state_ff;
      key_in    = key_ff;
      bcnt_in   = bcnt_ff;
      mstep_in  = mstep_ff;
      update_in = update_ff;
      amount_in = amount_ff;
      rows_in   = rows_ff;
      weff_in   = weff_ff;
      rpoly_in  = rpoly_ff;
      crc_in    = crc_ff;
      rem_in    = rem_ff;
      req_stall = hold || (state_ff != cmsc_pkg::F_IDLE);
      push      = 1'b0;
      unique case (state_ff)
         cmsc_pkg::F_IDLE: begin
            if (accept) begin
               if (flow) begin
                  key_in  = {req_dst_port, req_src_port, req_proto, req_dst_ip, req_src_ip};
                  bcnt_in = cmsc_pkg::BCNT_W'(cmsc_pkg::KEY_BYTES);
               end else begin
                  key_in  = {(cmsc_pkg::KEY_W - 32)'(0), req_int_key};
                  bcnt_in = cmsc_pkg::BCNT_W'(4);
               end
               update_in = !req_action[1];
               amount_in = flow ? 32'd1 : req_increment;
               if (cfg.row_count == '0) begin
                  rows_in = cmsc_pkg::ROWS_W'(1);
               end else if (32'(cfg.row_count) > cmsc_pkg::LANES) begin
                  rows_in = cmsc_pkg::ROWS_W'(cmsc_pkg::LANES);
               end else begin
                  rows_in = cfg.row_count;
               end
               if (cfg.width == '0) begin
                  weff_in = cmsc_pkg::REM_W'(1);
               end else if (32'(cfg.width) > cmsc_pkg::MAX_WIDTH) begin
                  weff_in = cmsc_pkg::REM_W'(cmsc_pkg::MAX_WIDTH);
               end else begin
                  weff_in = cmsc_pkg::REM_W'(cfg.width);
               end
               for (int i = 0; i < cmsc_pkg::LANES; i++) begin
                  rpoly_in[i] = cmsc_pkg::bit_rev32(cfg.poly[i]);
                  crc_in[i]   = cmsc_pkg::CRC_ALL_ONES;
               end
               state_in = cmsc_pkg::F_CRC;
            end
         end
         cmsc_pkg::F_CRC: begin
            for (int i = 0; i < cmsc_pkg::LANES; i++) begin
               crc_in[i] = cmsc_pkg::crc_byte(crc_ff[i], rpoly_ff[i], key_ff[7:0]);
            end
            key_in  = key_ff >> 8;
            bcnt_in = bcnt_ff - cmsc_pkg::BCNT_W'(1);
            if (bcnt_ff == cmsc_pkg::BCNT_W'(1)) begin
               for (int i = 0; i < cmsc_pkg::LANES; i++) begin
                  crc_in[i] = crc_in[i] ^ cmsc_pkg::CRC_ALL_ONES;
                  rem_in[i] = '0;
               end
               mstep_in = '0;
               state_in = cmsc_pkg::F_MOD;
            end
         end
         cmsc_pkg::F_MOD: begin
            // Restoring remainder; the CRC register doubles as the dividend shifter.
            for (int i = 0; i < cmsc_pkg::LANES; i++) begin
               r = {1'b0, rem_ff[i]};
               d = crc_ff[i];
               for (int k = 0; k < cmsc_pkg::MOD_BITS; k++) begin
                  r = {r[cmsc_pkg::COL_W-1:0], d[31]};
                  d = d << 1;
                  if (r >= weff_ff) begin
                     r = r - weff_ff;
                  end
               end
               rem_in[i] = r[cmsc_pkg::COL_W-1:0];
               crc_in[i] = d;
            end
            mstep_in = mstep_ff + cmsc_pkg::MSTEP_W'(1);
            if (mstep_ff == cmsc_pkg::MSTEP_W'(cmsc_pkg::MOD_STEPS - 1)) begin
               state_in = cmsc_pkg::F_PUSH;
            end
         end
         cmsc_pkg::F_PUSH: begin
            if (!qstat.full) begin
               push     = 1'b1;
               state_in = cmsc_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = cmsc_pkg::F_IDLE;
         end
      endcase
   end

   assign job.update = update_ff;
   assign job.amount = amount_ff;
   assign job.rows   = rows_ff;
   assign job.col    = rem_ff;

endmodule

// ===== hdl/cmsc_queue.sv =====
// Two-entry queue of classified items between the front and back ends.
// Depends on cmsc_pkg.
module cmsc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cmsc_pkg::job_type          push_job,
   input  logic                       pop,
   output cmsc_pkg::job_type          head,
   output cmsc_pkg::queue_status_type status
);

   cmsc_pkg::job_type slot_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

   assign head         = slot_ff[rptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

// ===== hdl/cmsc_back.sv =====
// Back end: counter banks, read-modify-write, minimum and running total.
// Depends on cmsc_pkg.
module cmsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cmsc_pkg::job_type          head,
   input  cmsc_pkg::queue_status_type qstat,
   output logic                       pop,
   output logic                       clearing,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_estimate,
   output logic [31:0]                rsp_total_count
);

   cmsc_pkg::back_state_type state_ff, state_in;
   cmsc_pkg::job_type                     job_ff, job_in;
   logic [cmsc_pkg::COL_W-1:0]            clr_ff, clr_in;
   logic [31:0]                           total_ff, total_in;
   logic                                  valid_ff, valid_in;
   logic [31:0]                           est_ff, est_in;
   logic [31:0]                           tout_ff, tout_in;
   logic [cmsc_pkg::LANES-1:0][31:0]      rdata_ff;
   logic [cmsc_pkg::LANES-1:0]            wen;
   logic [cmsc_pkg::LANES-1:0][cmsc_pkg::COL_W-1:0] waddr;
   logic [cmsc_pkg::LANES-1:0][31:0]      wdata;

   // One bank per row; read data is registered.
   for (genvar g = 0; g < cmsc_pkg::LANES; g++) begin : g_bank
      logic [31:0] mem [cmsc_pkg::MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (wen[g]) begin
            mem[waddr[g]] <= wdata[g];
         end
         rdata_ff[g] <= mem[head.col[g]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmsc_pkg::B_CLEAR;
         clr_ff   <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
      job_ff  <= job_in;
      est_ff  <= est_in;
      tout_ff <= tout_in;
   end

   // Clearing pass, then pop, read and write back.
   always_comb begin
      logic [31:0] m;
      state_in = state_ff;
      clr_in   = clr_ff;
      total_in = total_ff;
      job_in   = job_ff;
      est_in   = est_ff;
      tout_in  = tout_ff;
      valid_in = valid_ff && rsp_stall;
      pop      = 1'b0;
      clearing = 1'b0;
      wen      = '0;
      m        = rdata_ff[0];
      for (int i = 0; i < cmsc_pkg::LANES; i++) begin
         waddr[i] = job_ff.col[i];
         wdata[i] = rdata_ff[i] + job_ff.amount;
      end
      unique case (state_ff)
         cmsc_pkg::B_CLEAR: begin
            clearing = 1'b1;
            for (int i = 0; i < cmsc_pkg::LANES; i++) begin
               wen[i]   = 1'b1;
               waddr[i] = clr_ff;
               wdata[i] = '0;
            end
            clr_in = clr_ff + cmsc_pkg::COL_W'(1);
            if (clr_ff == cmsc_pkg::COL_W'(cmsc_pkg::MAX_WIDTH - 1)) begin
               state_in = cmsc_pkg::B_IDLE;
            end
         end
         cmsc_pkg::B_IDLE: begin
            if (!qstat.empty && (!valid_ff || !rsp_stall)) begin
               pop      = 1'b1;
               job_in   = head;
               state_in = cmsc_pkg::B_READ;
            end
         end
         cmsc_pkg::B_READ: begin
            for (int i = 0; i < cmsc_pkg::LANES; i++) begin
               wen[i] = job_ff.update && (i < 32'(job_ff.rows));
               if (i > 0 && i < 32'(job_ff.rows) &&
                   $signed(rdata_ff[i]) < $signed(m)) begin
                  m = rdata_ff[i];
               end
            end
            if (job_ff.update) begin
               total_in = total_ff + job_ff.amount;
            end
            est_in   = job_ff.update ? 32'd0 : m;
            tout_in  = total_in;
            valid_in = 1'b1;
            state_in = cmsc_pkg::B_IDLE;
         end
         default: begin
            state_in = cmsc_pkg::B_IDLE;
         end
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_estimate    = est_ff;
   assign rsp_total_count = tout_ff;

endmodule

// ===== hdl/count_min_sketch_crc_rows.sv =====
// Top level of the count-min sketch with CRC-32 row hashes: registers,
// front end, queue and back end. Depends on cmsc_pkg and the cmsc_ modules.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  action, key fields, increment
//   rsp       out        rsp_valid / rsp_stall  estimate, total_count
//   csr       in/out     psel/penable/pready    paddr, pwdata, prdata
//
// An item takes a load step, one step per key byte through the CRC lanes
// (4 or 13), the remainder steps and a push step that waits while the queue
// is full; the hash front end sets the rate. The back end reads the banks
// for an item, then writes back, before it pops the next item. After reset
// a clearing pass zeroes the counter banks; no item is taken meanwhile.
// A stalled result leaves the front end running until the two-entry queue
// fills.
module count_min_sketch_crc_rows (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_int_key,
   input  logic [31:0] req_increment,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [7:0]  req_proto,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_estimate,
   output logic [31:0] rsp_total_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cmsc_pkg::cfg_type          cfg_ff, cfg_in;
   cmsc_pkg::job_type          push_job, head;
   cmsc_pkg::queue_status_type qstat;
   logic                       push, pop, clearing, wr;
   logic [2:0]                 idx;

   assign pready = 1'b1;
   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            cmsc_pkg::REG_ROW_COUNT: cfg_in.row_count = pwdata[cmsc_pkg::ROWS_W-1:0];
            cmsc_pkg::REG_WIDTH:     cfg_in.width     = pwdata[cmsc_pkg::WID_W-1:0];
            cmsc_pkg::REG_POLY_0:    cfg_in.poly[0]   = pwdata;
            cmsc_pkg::REG_POLY_1:    cfg_in.poly[1]   = pwdata;
            cmsc_pkg::REG_POLY_2:    cfg_in.poly[2]   = pwdata;
            cmsc_pkg::REG_POLY_3:    cfg_in.poly[3]   = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count <= cmsc_pkg::ROWS_W'(4);
         cfg_ff.width     <= cmsc_pkg::WID_W'(1024);
         cfg_ff.poly[0]   <= 32'h04C1_1DB7;
         cfg_ff.poly[1]   <= 32'h1EDC_6F41;
         cfg_ff.poly[2]   <= 32'h7EC8_9B91;
         cfg_ff.poly[3]   <= 32'h82F6_3B78;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      unique case (idx)
         cmsc_pkg::REG_ROW_COUNT: prdata = {29'd0, cfg_ff.row_count};
         cmsc_pkg::REG_WIDTH:     prdata = {21'd0, cfg_ff.width};
         cmsc_pkg::REG_POLY_0:    prdata = cfg_ff.poly[0];
         cmsc_pkg::REG_POLY_1:    prdata = cfg_ff.poly[1];
         cmsc_pkg::REG_POLY_2:    prdata = cfg_ff.poly[2];
         cmsc_pkg::REG_POLY_3:    prdata = cfg_ff.poly[3];
         default:                 prdata = 32'd0;
      endcase
   end

   cmsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .hold          (clearing),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_int_key   (req_int_key),
      .req_increment (req_increment),
      .req_src_ip    (req_src_ip),
      .req_dst_ip    (req_dst_ip),
      .req_proto     (req_proto),
      .req_src_port  (req_src_port),
      .req_dst_port  (req_dst_port),
      .qstat         (qstat),
      .push          (push),
      .job           (push_job)
   );

   cmsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (qstat)
   );

   cmsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .qstat           (qstat),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_estimate    (rsp_estimate),
      .rsp_total_count (rsp_total_count)
   );

   // The queue is never pushed when full nor popped when empty.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty) else $error("queue pop while empty");
   // No item enters and no result leaves during the clearing pass.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (req_stall && !rsp_valid)) else $error("activity while clearing");

endmodule

// ===== sim/tb_count_min_sketch_crc_rows.sv =====
// Self-checking testbench for count_min_sketch_crc_rows: random and directed
// sketch updates and estimates against a behavioral sketch. Depends on cmsc_pkg.
module tb_count_min_sketch_crc_rows;

   typedef struct {
      cmsc_pkg::action_type action;
      logic [31:0] int_key;
      logic [31:0] increment;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  proto;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } sketch_item_type;

   typedef struct {
      logic [31:0] estimate;
      logic [31:0] total_count;
   } sketch_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [31:0] req_int_key = '0;
   logic [31:0] req_increment = '0;
   logic [31:0] req_src_ip = '0;
   logic [31:0] req_dst_ip = '0;
   logic [7:0]  req_proto = '0;
   logic [15:0] req_src_port = '0;
   logic [15:0] req_dst_port = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_estimate;
   logic [31:0] rsp_total_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   count_min_sketch_crc_rows uut (.*);

   always #4 clock = ~clock;

   // Behavioral sketch state and its configuration copy.
   logic [31:0] sketch_cells [cmsc_pkg::MAX_ROWS][cmsc_pkg::MAX_WIDTH];
   logic [31:0] running_total;
   logic [2:0]  cfg_rows;
   logic [10:0] cfg_width;
   logic [31:0] cfg_poly [cmsc_pkg::POLY_REGS];

   sketch_item_type   pending_items [$];
   sketch_result_type expected_results [$];
   int                fail_count = 0;
   int                cycle_count = 0;
   bit                driver_enable = 1'b0;

   function automatic logic [31:0] hash_row(logic [31:0] poly, sketch_item_type it);
      logic [31:0] rp;
      logic [31:0] crc;
      logic [103:0] key_bytes;
      int           nbytes;
      for (int b = 0; b < 32; b++) rp[b] = poly[31-b];
      if (it.action[0]) begin
         key_bytes = {it.dst_port, it.src_port, it.proto, it.dst_ip, it.src_ip};
         nbytes = 13;
      end else begin
         key_bytes = {72'd0, it.int_key};
         nbytes = 4;
      end
      crc = 32'hFFFF_FFFF;
      for (int i = 0; i < nbytes; i++) begin
         crc = crc ^ {24'd0, key_bytes[8*i +: 8]};
         for (int b = 0; b < 8; b++) crc = crc[0] ? ((crc >> 1) ^ rp) : (crc >> 1);
      end
      return crc ^ 32'hFFFF_FFFF;
   endfunction

   // Apply one item to the sketch and return the result it must produce.
   function automatic sketch_result_type sketch_apply(sketch_item_type it);
      sketch_result_type res;
      int          rows;
      int          w;
      int          col;
      logic [31:0] amount;
      logic signed [31:0] low;
      bit          upd;
      rows = (cfg_rows < 1) ? 1 :
             (cfg_rows > cmsc_pkg::MAX_ROWS ? cmsc_pkg::MAX_ROWS : cfg_rows);
      w = (cfg_width < 1) ? 1 :
          (cfg_width > cmsc_pkg::MAX_WIDTH ? cmsc_pkg::MAX_WIDTH : cfg_width);
      upd = (it.action == cmsc_pkg::ACT_UPD_INT) || (it.action == cmsc_pkg::ACT_UPD_FLOW);
      amount = it.action[0] ? 32'd1 : it.increment;
      low = '0;
      if (upd) running_total += amount;
      for (int r = 0; r < rows; r++) begin
         col = hash_row(cfg_poly[r], it) % w;
         if (upd) sketch_cells[r][col] += amount;
         else if (r == 0 || $signed(sketch_cells[r][col]) < low) low = sketch_cells[r][col];
      end
      res.estimate = upd ? 32'd0 : low;
      res.total_count = running_total;
      return res;
   endfunction

   // Driver: one transfer per queued item, with a random gap between items.
   int send_gap = 0;
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         sketch_item_type it;
         it = pending_items.pop_front();
         expected_results.push_back(sketch_apply(it));
         req_valid <= 1'b0;
         send_gap <= $urandom_range(4) * $urandom_range(1);
      end else if (!req_valid && driver_enable && pending_items.size() > 0) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else begin
            req_valid     <= 1'b1;
            req_action    <= pending_items[0].action;
            req_int_key   <= pending_items[0].int_key;
            req_increment <= pending_items[0].increment;
            req_src_ip    <= pending_items[0].src_ip;
            req_dst_ip    <= pending_items[0].dst_ip;
            req_proto     <= pending_items[0].proto;
            req_src_port  <= pending_items[0].src_port;
            req_dst_port  <= pending_items[0].dst_port;
         end
      end
   end

   // Monitor: check each result transfer and draw the next stall stretch.
   int stall_left = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            sketch_result_type e;
            e = expected_results.pop_front();
            if (rsp_estimate !== e.estimate) begin
               $error("estimate: expected %0h actual %0h", e.estimate, rsp_estimate);
               fail_count++;
            end
            if (rsp_total_count !== e.total_count) begin
               $error("total_count: expected %0h actual %0h",
                      e.total_count, rsp_total_count);
               fail_count++;
            end
         end
         stall_left = $urandom_range(4) * $urandom_range(1);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         cmsc_pkg::REG_ROW_COUNT: cfg_rows = value[2:0];
         cmsc_pkg::REG_WIDTH:     cfg_width = value[10:0];
         default:                 cfg_poly[idx - cmsc_pkg::REG_POLY_0] = value;
      endcase
   endtask

   // Send every queued item and wait until all results are back.
   task automatic drain();
      driver_enable = 1'b1;
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      driver_enable = 1'b0;
      repeat (40) @(posedge clock);
   endtask

   function automatic sketch_item_type random_item(int key_span);
      sketch_item_type it;
      it.action    = cmsc_pkg::action_type'($urandom_range(3));
      it.int_key   = (key_span > 0) ? $urandom_range(key_span) : $urandom;
      it.increment = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20) - 10;
      it.src_ip    = (key_span > 0) ? $urandom_range(key_span) : $urandom;
      it.dst_ip    = $urandom;
      it.proto     = 8'($urandom);
      it.src_port  = 16'($urandom);
      it.dst_port  = 16'($urandom);
      return it;
   endfunction

   function automatic sketch_item_type make_item(cmsc_pkg::action_type a, logic [31:0] k,
                                                 logic [31:0] inc, logic [31:0] f);
      sketch_item_type it;
      it.action = a; it.int_key = k; it.increment = inc;
      it.src_ip = f; it.dst_ip = ~f; it.proto = f[7:0];
      it.src_port = f[15:0]; it.dst_port = ~f[15:0];
      return it;
   endfunction

   // Stimulus: directed extremes, then random phases over several settings.
   initial begin
      for (int r = 0; r < cmsc_pkg::MAX_ROWS; r++)
         for (int c = 0; c < cmsc_pkg::MAX_WIDTH; c++) sketch_cells[r][c] = '0;
      running_total = '0;
      cfg_rows = 3'd4; cfg_width = 11'd1024;
      cfg_poly[0] = 32'h04C11DB7; cfg_poly[1] = 32'h1EDC6F41;
      cfg_poly[2] = 32'h7EC89B91; cfg_poly[3] = 32'h82F63B78;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of every field, every action, overflow of counters.
      pending_items.push_back(make_item(cmsc_pkg::ACT_EST_INT, 32'd0, 32'd0, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_UPD_INT, 32'hFFFF_FFFF,
                                        32'h7FFF_FFFF, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_UPD_INT, 32'hFFFF_FFFF,
                                        32'h7FFF_FFFF, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_EST_INT, 32'hFFFF_FFFF,
                                        32'd0, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_UPD_INT, 32'd0, 32'h8000_0000, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_EST_INT, 32'd0, 32'd0, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_UPD_FLOW, 32'd0, 32'd0, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(cmsc_pkg::ACT_UPD_FLOW, 32'd0, 32'd0, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_EST_FLOW, 32'd0, 32'd0, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(cmsc_pkg::ACT_EST_FLOW, 32'd0, 32'd0, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_UPD_INT, 32'h1234_5678,
                                        32'hFFFF_FFFF, 32'd0));
      pending_items.push_back(make_item(cmsc_pkg::ACT_EST_INT, 32'h1234_5678, 32'd0, 32'd0));
      // The sender holds off here until all results are back.
      drain();

      // Settings: width and rows one, then zero, oversize, poly edges, random.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_reg(cmsc_pkg::REG_ROW_COUNT, 32'd1);
               write_reg(cmsc_pkg::REG_WIDTH, 32'd1);
            end
            1: begin
               write_reg(cmsc_pkg::REG_ROW_COUNT, 32'd0);
               write_reg(cmsc_pkg::REG_WIDTH, 32'd0);
            end
            2: begin
               write_reg(cmsc_pkg::REG_ROW_COUNT, 32'd7);
               write_reg(cmsc_pkg::REG_WIDTH, 32'h7FF);
            end
            3: begin
               write_reg(cmsc_pkg::REG_ROW_COUNT, 32'd4);
               write_reg(cmsc_pkg::REG_WIDTH, 32'd1024);
               write_reg(cmsc_pkg::REG_POLY_0, 32'd0);
               write_reg(cmsc_pkg::REG_POLY_1, 32'hFFFF_FFFF);
               write_reg(cmsc_pkg::REG_POLY_2, $urandom);
               write_reg(cmsc_pkg::REG_POLY_3, $urandom);
            end
            default: begin
               write_reg(cmsc_pkg::REG_ROW_COUNT, $urandom_range(7));
               write_reg(cmsc_pkg::REG_WIDTH, $urandom_range(1100));
               write_reg(3'(cmsc_pkg::REG_POLY_0 + $urandom_range(3)), $urandom);
            end
         endcase
         // Small key spans make estimates hit updated counters.
         for (int n = 0; n < 175; n++)
            pending_items.push_back(random_item((n % 3 == 0) ? 0 : 15));
         drain();
      end

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
